// ----- src/lcar_pkg.sv -----
`timescale 1ns / 1ps

package lcar_pkg;

  // Converter word width default and the widths of the fixed fields.
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COUNT_W         = 16;
  localparam int SCALE_W         = 32;
  localparam int WEIGHT_W        = 48;
  localparam int CFG_IDX_W       = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd1;

  // Register reset values.
  localparam logic [1:0]         GAIN_RESET  = 2'd1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

  // Operation codes on the input beat.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WEIGH = 2'd1;
  localparam logic [1:0] OP_TARE  = 2'd2;

  // Status codes on the result beat.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_BUSY = 2'd2;

  // Saturation limits of the weight output.
  localparam logic [WEIGHT_W-1:0] W48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [WEIGHT_W-1:0] W48_MIN = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_CLOCK
  } phase_t;

  typedef enum logic [2:0] {
    SQ_TICK,
    SQ_AVG_GO,
    SQ_AVG_RUN,
    SQ_DIFF,
    SQ_WT_GO,
    SQ_WT_RUN
  } seq_t;

endpackage

// ----- src/load_cell_adc_reader_averaging_unit.sv -----
`timescale 1ns / 1ps

// Latency: a tick's result beat is registered, valid the cycle after the input beat;
//   the beat of the tick that ends a command waits until the arithmetic is done.
// Throughput: one tick per cycle while results are taken; that last tick holds the input
//   off through its passes (one for a tare, up to two for a weigh) through one shared divider.
// Reset: synchronous, active high; clears the sequencer, read state, tare offset and
//   result valid, and loads gain_pulses = 1 and scale_factor = 1.0 (Q16.16).
module load_cell_adc_reader_averaging_unit #(
  parameter int SAMPLE_BITS = lcar_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel: one half period of the converter serial clock per beat
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         op,
  input  logic [lcar_pkg::COUNT_W-1:0]       average_count,
  input  logic                               dout_level,
  // result channel: one beat per input beat
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               sck_level,
  output logic                               done_res,
  output logic [1:0]                         status,
  output logic signed [lcar_pkg::WEIGHT_W-1:0] weight,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [lcar_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcar_pkg::SCALE_W-1:0]       cfg_data
);

  // Widths derived from the converter word size.
  localparam int SUM_W  = SAMPLE_BITS + lcar_pkg::COUNT_W;  // exact sum of 65535 words
  localparam int AVG_W  = SAMPLE_BITS + 8;                  // Q.8 average / tare offset
  localparam int DIFF_W = AVG_W + 1;                        // average minus offset
  localparam int DIV_W  = DIFF_W + 16;                      // widest dividend (diff * 65536)
  localparam int CMP_W  = (DIV_W > lcar_pkg::WEIGHT_W) ? DIV_W : lcar_pkg::WEIGHT_W;
  localparam int PC_W   = $clog2(SAMPLE_BITS + 4);
  localparam int W_W    = lcar_pkg::WEIGHT_W;

  localparam logic [CMP_W-1:0] POS_LIM = CMP_W'(lcar_pkg::W48_MAX);
  localparam logic [CMP_W-1:0] NEG_LIM = CMP_W'(lcar_pkg::W48_MIN);

  // Configuration registers.
  logic [1:0]                  gain_pulses;
  logic [lcar_pkg::SCALE_W-1:0] scale_factor;

  // Read state.
  lcar_pkg::phase_t            phase, phase_next;
  logic [PC_W-1:0]             pulse_count, pulse_count_next;
  logic [SAMPLE_BITS-1:0]      shift_word, shift_word_next;
  logic                        clock_out, clock_out_next;
  logic signed [SUM_W-1:0]     running_sum, running_sum_next;
  logic [lcar_pkg::COUNT_W-1:0] reads_done, reads_done_next;
  logic [lcar_pkg::COUNT_W-1:0] reads_wanted, reads_wanted_next;
  logic                        tare_mode, tare_mode_next;
  logic signed [AVG_W-1:0]     tare_offset;

  // Sequencer and arithmetic holding registers.
  lcar_pkg::seq_t              seq, seq_next;
  logic signed [AVG_W-1:0]     avg_reg;
  logic signed [DIFF_W-1:0]    diff_reg;
  logic                        neg;

  // Tick decode.
  logic                        accept;
  logic                        cmd;
  logic [1:0]                  gp;
  logic [PC_W-1:0]             pulse_inc;
  logic                        word_end;
  logic [lcar_pkg::COUNT_W-1:0] reads_inc;
  logic                        read_last;
  logic                        tick_sck;
  logic                        tick_done;
  logic [1:0]                  tick_status;

  // Divider hookup.
  logic                        div_start;
  logic [DIV_W-1:0]            div_dividend;
  logic [lcar_pkg::SCALE_W-1:0] div_divisor;
  logic                        div_done;
  logic [DIV_W-1:0]            div_q;

  // Arithmetic around the divider.
  logic [SUM_W-1:0]            sum_mag;
  logic [DIFF_W-1:0]           diff_mag;
  logic [AVG_W-1:0]            q_avg;
  logic signed [AVG_W-1:0]     avg_val;
  logic [CMP_W-1:0]            q_cmp;
  logic [W_W-1:0]              q_low;
  logic [W_W-1:0]              sat_weight;
  logic [W_W-1:0]              zero_scale_weight;

  // Result load controls.
  logic                        res_load;
  logic                        res_sck;
  logic                        res_done;
  logic [1:0]                  res_status;
  logic [W_W-1:0]              res_weight;

  assign accept    = in_valid && in_ready;
  assign cmd       = (op == lcar_pkg::OP_WEIGH) || (op == lcar_pkg::OP_TARE);
  assign gp        = (gain_pulses == 2'd0) ? 2'd1 : gain_pulses;
  assign pulse_inc = pulse_count + 1'b1;
  // A word ends on a low tick once the data bits and gain pulses are all sent.
  assign word_end  = (phase == lcar_pkg::PH_CLOCK) && clock_out &&
                     (pulse_inc >= (PC_W'(SAMPLE_BITS) + PC_W'(gp)));
  assign reads_inc = reads_done + 1'b1;
  assign read_last = word_end && (reads_inc == reads_wanted);

  // ---------------------------------------------------------------------------
  // Read phase: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_next = phase;
    unique case (phase)
      lcar_pkg::PH_IDLE: begin
        if (cmd && (average_count != '0)) begin
          phase_next = lcar_pkg::PH_WAIT;
        end
      end
      lcar_pkg::PH_WAIT: begin
        // Data line low means a conversion is ready to clock out.
        if (!dout_level) begin
          phase_next = lcar_pkg::PH_CLOCK;
        end
      end
      lcar_pkg::PH_CLOCK: begin
        if (word_end) begin
          phase_next = read_last ? lcar_pkg::PH_IDLE : lcar_pkg::PH_WAIT;
        end
      end
      default: phase_next = lcar_pkg::PH_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Read phase: outputs and datapath updates for one tick.
  // ---------------------------------------------------------------------------
  always_comb begin
    pulse_count_next  = pulse_count;
    shift_word_next   = shift_word;
    clock_out_next    = clock_out;
    running_sum_next  = running_sum;
    reads_done_next   = reads_done;
    reads_wanted_next = reads_wanted;
    tare_mode_next    = tare_mode;
    tick_sck          = 1'b0;
    tick_done         = 1'b0;
    tick_status       = lcar_pkg::STAT_OK;
    unique case (phase)
      lcar_pkg::PH_IDLE: begin
        if (cmd) begin
          if (average_count == '0) begin
            // Reject a zero count at once.
            tick_done   = 1'b1;
            tick_status = lcar_pkg::STAT_ZERO;
          end else begin
            reads_wanted_next = average_count;
            reads_done_next   = '0;
            running_sum_next  = '0;
            tare_mode_next    = (op == lcar_pkg::OP_TARE);
          end
        end
      end
      lcar_pkg::PH_WAIT: begin
        if (cmd) begin
          tick_status = lcar_pkg::STAT_BUSY;
        end
        if (!dout_level) begin
          pulse_count_next = '0;
          clock_out_next   = 1'b0;
          shift_word_next  = '0;
        end
      end
      lcar_pkg::PH_CLOCK: begin
        if (cmd) begin
          tick_status = lcar_pkg::STAT_BUSY;
        end
        if (!clock_out) begin
          // High tick: sample the data line while data bits remain.
          clock_out_next = 1'b1;
          tick_sck       = 1'b1;
          if (pulse_count < PC_W'(SAMPLE_BITS)) begin
            shift_word_next = {shift_word[SAMPLE_BITS-2:0], dout_level};
          end
        end else begin
          // Low tick: count the pulse, fold in the word when it ends.
          clock_out_next   = 1'b0;
          pulse_count_next = pulse_inc;
          if (word_end) begin
            running_sum_next = running_sum +
                {{lcar_pkg::COUNT_W{shift_word[SAMPLE_BITS-1]}}, shift_word};
            reads_done_next  = reads_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Arithmetic feeding and leaving the shared divider.
  // ---------------------------------------------------------------------------
  assign sum_mag  = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
  assign diff_mag = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
  assign q_avg    = div_q[AVG_W-1:0];
  assign avg_val  = neg ? -$signed(q_avg) : $signed(q_avg);

  // Saturate the quotient magnitude to the signed 48-bit range.
  assign q_cmp = CMP_W'(div_q);
  assign q_low = q_cmp[W_W-1:0];
  always_comb begin
    if (neg) begin
      sat_weight = (q_cmp > NEG_LIM) ? lcar_pkg::W48_MIN : W_W'(-q_low);
    end else begin
      sat_weight = (q_cmp > POS_LIM) ? lcar_pkg::W48_MAX : q_low;
    end
  end

  // A zero scale saturates toward the sign of the difference; a zero difference gives zero.
  always_comb begin
    if (diff_reg == '0) begin
      zero_scale_weight = '0;
    end else if (diff_reg[DIFF_W-1]) begin
      zero_scale_weight = lcar_pkg::W48_MIN;
    end else begin
      zero_scale_weight = lcar_pkg::W48_MAX;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    seq_next = seq;
    unique case (seq)
      lcar_pkg::SQ_TICK: begin
        if (accept && read_last) begin
          seq_next = lcar_pkg::SQ_AVG_GO;
        end
      end
      lcar_pkg::SQ_AVG_GO:  seq_next = lcar_pkg::SQ_AVG_RUN;
      lcar_pkg::SQ_AVG_RUN: begin
        if (div_done) begin
          seq_next = tare_mode ? lcar_pkg::SQ_TICK : lcar_pkg::SQ_DIFF;
        end
      end
      lcar_pkg::SQ_DIFF:    seq_next = lcar_pkg::SQ_WT_GO;
      lcar_pkg::SQ_WT_GO: begin
        seq_next = (scale_factor == '0) ? lcar_pkg::SQ_TICK : lcar_pkg::SQ_WT_RUN;
      end
      lcar_pkg::SQ_WT_RUN: begin
        if (div_done) begin
          seq_next = lcar_pkg::SQ_TICK;
        end
      end
      default: seq_next = lcar_pkg::SQ_TICK;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'({sum_mag, 8'b0});
    div_divisor  = lcar_pkg::SCALE_W'(reads_wanted);
    res_load     = 1'b0;
    res_sck      = tick_sck;
    res_done     = tick_done;
    res_status   = tick_status;
    res_weight   = '0;
    unique case (seq)
      lcar_pkg::SQ_TICK: begin
        // Take a tick only when the result slot is free or draining this cycle.
        in_ready = !out_valid || out_ready;
        // The last read of a command holds its result until the math is done.
        res_load = accept && !read_last;
      end
      lcar_pkg::SQ_AVG_GO: begin
        div_start = 1'b1;
      end
      lcar_pkg::SQ_AVG_RUN: begin
        if (div_done && tare_mode) begin
          res_load   = 1'b1;
          res_sck    = 1'b0;
          res_done   = 1'b1;
          res_status = lcar_pkg::STAT_OK;
        end
      end
      lcar_pkg::SQ_DIFF: begin
      end
      lcar_pkg::SQ_WT_GO: begin
        div_dividend = {diff_mag, 16'b0};
        div_divisor  = scale_factor;
        if (scale_factor == '0) begin
          res_load   = 1'b1;
          res_sck    = 1'b0;
          res_done   = 1'b1;
          res_status = lcar_pkg::STAT_OK;
          res_weight = zero_scale_weight;
        end else begin
          div_start = 1'b1;
        end
      end
      lcar_pkg::SQ_WT_RUN: begin
        if (div_done) begin
          res_load   = 1'b1;
          res_sck    = 1'b0;
          res_done   = 1'b1;
          res_status = lcar_pkg::STAT_OK;
          res_weight = sat_weight;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_pulses  <= lcar_pkg::GAIN_RESET;
      scale_factor <= lcar_pkg::SCALE_RESET;
      phase        <= lcar_pkg::PH_IDLE;
      pulse_count  <= '0;
      shift_word   <= '0;
      clock_out    <= 1'b0;
      running_sum  <= '0;
      reads_done   <= '0;
      reads_wanted <= '0;
      tare_mode    <= 1'b0;
      tare_offset  <= '0;
      seq          <= lcar_pkg::SQ_TICK;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lcar_pkg::REG_GAIN:  gain_pulses  <= cfg_data[1:0];
          lcar_pkg::REG_SCALE: scale_factor <= cfg_data;
          default: begin
          end
        endcase
      end

      // Advance the read state once per accepted tick.
      if (accept) begin
        phase        <= phase_next;
        pulse_count  <= pulse_count_next;
        shift_word   <= shift_word_next;
        clock_out    <= clock_out_next;
        running_sum  <= running_sum_next;
        reads_done   <= reads_done_next;
        reads_wanted <= reads_wanted_next;
        tare_mode    <= tare_mode_next;
      end

      seq <= seq_next;

      if ((seq == lcar_pkg::SQ_AVG_RUN) && div_done && tare_mode) begin
        tare_offset <= avg_val;
      end

      // Hold a result beat until taken; load a new one into the freed slot.
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (res_load) begin
      sck_level <= res_sck;
      done_res  <= res_done;
      status    <= res_status;
      weight    <= $signed(res_weight);
    end
    if (seq == lcar_pkg::SQ_AVG_GO) begin
      neg <= running_sum[SUM_W-1];
    end else if (seq == lcar_pkg::SQ_WT_GO) begin
      neg <= diff_reg[DIFF_W-1];
    end
    if ((seq == lcar_pkg::SQ_AVG_RUN) && div_done) begin
      avg_reg <= avg_val;
    end
    if (seq == lcar_pkg::SQ_DIFF) begin
      diff_reg <= {avg_reg[AVG_W-1], avg_reg} - {tare_offset[AVG_W-1], tare_offset};
    end
  end

  // One divider serves both the average and the scaling.
  lcar_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (lcar_pkg::SCALE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

// ----- src/lcar_div.sv -----
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per cycle.
module lcar_div #(
  parameter int DIVIDEND_W = lcar_pkg::SAMPLE_BITS_DEF + 25,
  parameter int DIVISOR_W  = lcar_pkg::SCALE_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [CNT_W-1:0]     steps;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   trial_sub;
  logic                 fits;

  assign trial     = {rem, quotient[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        rem      <= '0;
        dvs      <= divisor;
        steps    <= CNT_W'(DIVIDEND_W);
      end else if (steps != '0) begin
        quotient <= {quotient[DIVIDEND_W-2:0], fits};
        rem      <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        steps    <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/lcar_checks.sv -----
`timescale 1ns / 1ps

module lcar_checks (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               sck_level,
  input logic                               done_res,
  input logic [1:0]                         status,
  input logic signed [lcar_pkg::WEIGHT_W-1:0] weight
);

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight) && $stable(status))
    else $error("result beat changed while stalled");

  // Input is never taken while the result slot stays full.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken with result slot blocked");

  // A finished or rejected command never reports busy.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> status != lcar_pkg::STAT_BUSY)
    else $error("done beat with busy status");

  // A nonzero weight only comes with a clean finish on a low clock tick.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (weight != '0) |-> done_res && !sck_level &&
                                    (status == lcar_pkg::STAT_OK))
    else $error("weight outside a finished weigh");

endmodule

bind load_cell_adc_reader_averaging_unit lcar_checks u_lcar_checks (.*);
